[src/hid_key_report_builder_core_assert.svh]
`ifndef HID_KEY_REPORT_BUILDER_CORE_ASSERT_SVH
`define HID_KEY_REPORT_BUILDER_CORE_ASSERT_SVH

// Both macros expect clk and rst_n in the scope where they are used.

`define HKRB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hkrb: same-cycle check failed");

`define HKRB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hkrb: next-cycle check failed");

`endif

[src/hkrb_pkg.sv]
`default_nettype none

package hkrb_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int WORD_W      = 64;
  localparam int CNT_W       = 4;
  localparam int MAX_RESULTS = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_NKRO_MODE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPORT_GAP = 1'd1;

  localparam logic [7:0] MOD_FIRST        = 8'hE0;
  localparam logic [7:0] MOD_LAST         = 8'hE7;
  localparam logic [7:0] FIRST_BITMAP_KEY = 8'h04;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_MOD    = 3'd0,
    OP_BITMAP = 3'd1,
    OP_SLOT   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  // For OP_MOD code[2:0] is the modifier bit, for OP_BITMAP code is the bitmap bit.
  typedef struct packed {
    op_t        op;
    logic       press;
    logic [7:0] code;
    logic [7:0] mods;
  } cmd_t;

  typedef struct packed {
    logic       nkro_mode;
    logic [7:0] report_gap;
  } cfg_t;

endpackage

`default_nettype wire

[src/hkrb_front.sv]
`default_nettype none

module hkrb_front #(
  parameter int NKRO_REPORT_BYTES = 32
) (
  input  wire logic          rst_n,
  input  wire hkrb_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_kind,
  input  wire logic [7:0]    in_key_code,
  input  wire logic [7:0]    in_extra_mods,
  input  wire logic          in_key_pressed,
  input  wire logic          q_full,
  output logic               q_push,
  output hkrb_pkg::cmd_t     q_cmd
);
  import hkrb_pkg::*;

  localparam int BITMAP_BYTES = NKRO_REPORT_BYTES - 1;

  logic [7:0] bit_k;
  logic       is_mod;
  logic       in_bitmap;
  logic       keep;

  assign in_ready  = !q_full;
  assign bit_k     = in_key_code - FIRST_BITMAP_KEY;
  assign is_mod    = (in_key_code >= MOD_FIRST) && (in_key_code <= MOD_LAST);
  assign in_bitmap = cfg.nkro_mode && ({1'b0, bit_k[7:3]} < 6'(BITMAP_BYTES));

  always_comb begin
    keep        = 1'b1;
    q_cmd.op    = OP_TICK;
    q_cmd.press = in_key_pressed;
    q_cmd.code  = in_key_code;
    q_cmd.mods  = in_extra_mods;
    unique case (in_kind)
      KIND_KEY: begin
        if (is_mod) begin
          q_cmd.op = OP_MOD;
        end else if (in_bitmap) begin
          q_cmd.op   = OP_BITMAP;
          q_cmd.code = bit_k;
        end else begin
          q_cmd.op = OP_SLOT;
        end
      end
      KIND_CLEAR: q_cmd.op = OP_CLEAR;
      KIND_TICK:  q_cmd.op = OP_TICK;
      default:    keep = 1'b0;
    endcase
  end

  assign q_push = in_valid && !q_full && keep && rst_n;

endmodule

`default_nettype wire

[src/hkrb_cmd_queue.sv]
`default_nettype none

module hkrb_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire hkrb_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output hkrb_pkg::cmd_t      head
);
  import hkrb_pkg::*;

  cmd_t       entry_r [2];
  logic       wptr_r;
  logic       wptr_nxt;
  logic       rptr_r;
  logic       rptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign head    = entry_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt  = do_push ? !wptr_r : wptr_r;
    rptr_nxt  = do_pop ? !rptr_r : rptr_r;
    count_nxt = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (do_push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[src/hkrb_back.sv]
`default_nettype none

module hkrb_back #(
  parameter int BOOT_KEY_SLOTS    = 6,
  parameter int NKRO_REPORT_BYTES = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire hkrb_pkg::cfg_t cfg,
  input  wire logic           q_empty,
  input  wire hkrb_pkg::cmd_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_report_type,
  output logic [1:0]          out_word_index,
  output logic [63:0]         out_report_word,
  output logic                out_last
);
  import hkrb_pkg::*;

  `include "hid_key_report_builder_core_assert.svh"

  localparam int BITMAP_BYTES = NKRO_REPORT_BYTES - 1;
  localparam int BITMAP_BITS  = BITMAP_BYTES * 8;
  localparam int BOOT_BYTES   = BOOT_KEY_SLOTS + 2;
  localparam int BOOT_WORDS   = (BOOT_BYTES + 7) / 8;
  localparam int NKRO_WORDS   = (NKRO_REPORT_BYTES + 7) / 8;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t                 st_r, st_nxt;
  logic [7:0]             mods_r, mods_nxt;
  logic [7:0]             slots_r [BOOT_KEY_SLOTS];
  logic [7:0]             slots_nxt [BOOT_KEY_SLOTS];
  logic [BITMAP_BITS-1:0] bitmap_r, bitmap_nxt;
  logic                   boot_dirty_r, boot_dirty_nxt;
  logic                   nkro_dirty_r, nkro_dirty_nxt;
  logic [31:0]            tick_r, tick_nxt;
  logic [31:0]            next_send_r, next_send_nxt;
  logic [CNT_W-1:0]       word_cnt_r, word_cnt_nxt;
  logic [CNT_W-1:0]       n_boot_r, n_boot_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_type_r, out_type_nxt;
  logic [1:0]             out_index_r, out_index_nxt;
  logic [WORD_W-1:0]      out_word_r, out_word_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [31:0]            tick_inc;
  logic                   tick_send;
  logic                   send_tick;
  logic                   load;
  logic                   slot_found;
  logic [CNT_W-1:0]       n_nkro;
  logic [CNT_W-1:0]       n_sum;
  logic                   sel_boot;
  logic [CNT_W-1:0]       sel_idx;
  logic [WORD_W-1:0]      sel_word;
  logic [BOOT_WORDS*WORD_W-1:0] boot_vec;
  logic [NKRO_WORDS*WORD_W-1:0] nkro_vec;

  assign tick_inc  = tick_r + 32'd1;
  assign tick_send = tick_inc > next_send_r;
  assign n_nkro    = nkro_dirty_r ? CNT_W'(NKRO_WORDS) : '0;
  assign n_sum     = (boot_dirty_r ? CNT_W'(BOOT_WORDS) : '0) + n_nkro;
  assign send_tick = q_pop && (q_data.op == OP_TICK) && tick_send;

  always_comb begin
    boot_vec = '0;
    boot_vec[7:0] = mods_r;
    for (int i = 0; i < BOOT_KEY_SLOTS; i++) begin
      boot_vec[(i + 2) * 8 +: 8] = slots_r[i];
    end
    nkro_vec = '0;
    nkro_vec[7:0] = mods_r;
    nkro_vec[8 +: BITMAP_BITS] = bitmap_r;
  end

  always_comb begin
    sel_boot = word_cnt_r < n_boot_r;
    sel_idx  = sel_boot ? word_cnt_r : (word_cnt_r - n_boot_r);
    sel_word = '0;
    if (sel_boot) begin
      for (int w = 0; w < BOOT_WORDS; w++) begin
        if (sel_idx == CNT_W'(w)) begin
          sel_word = boot_vec[w * WORD_W +: WORD_W];
        end
      end
    end else begin
      for (int w = 0; w < NKRO_WORDS; w++) begin
        if (sel_idx == CNT_W'(w)) begin
          sel_word = nkro_vec[w * WORD_W +: WORD_W];
        end
      end
    end
  end

  always_comb begin
    st_nxt         = st_r;
    mods_nxt       = mods_r;
    slots_nxt      = slots_r;
    bitmap_nxt     = bitmap_r;
    boot_dirty_nxt = boot_dirty_r;
    nkro_dirty_nxt = nkro_dirty_r;
    tick_nxt       = tick_r;
    next_send_nxt  = next_send_r;
    word_cnt_nxt   = word_cnt_r;
    n_boot_nxt     = n_boot_r;
    total_nxt      = total_r;
    out_type_nxt   = out_type_r;
    out_index_nxt  = out_index_r;
    out_word_nxt   = out_word_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    load           = 1'b0;
    slot_found     = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_data.op)
            OP_MOD: begin
              mods_nxt[q_data.code[2:0]] = q_data.press;
              if (cfg.nkro_mode) nkro_dirty_nxt = 1'b1;
              else boot_dirty_nxt = 1'b1;
            end
            OP_BITMAP: begin
              mods_nxt = q_data.press ? (mods_r | q_data.mods) : (mods_r & ~q_data.mods);
              for (int i = 0; i < BITMAP_BITS; i++) begin
                if (8'(i) == q_data.code) bitmap_nxt[i] = q_data.press;
              end
              nkro_dirty_nxt = 1'b1;
            end
            OP_SLOT: begin
              mods_nxt = q_data.press ? (mods_r | q_data.mods) : (mods_r & ~q_data.mods);
              for (int i = 0; i < BOOT_KEY_SLOTS; i++) begin
                if (!slot_found && ((slots_r[i] == q_data.code) ||
                                    (q_data.press && (slots_r[i] == 8'd0)))) begin
                  slot_found   = 1'b1;
                  slots_nxt[i] = q_data.press ? q_data.code : 8'd0;
                end
              end
              if (slot_found) boot_dirty_nxt = 1'b1;
            end
            OP_CLEAR: begin
              mods_nxt   = '0;
              bitmap_nxt = '0;
              for (int i = 0; i < BOOT_KEY_SLOTS; i++) begin
                slots_nxt[i] = 8'd0;
              end
              if (cfg.nkro_mode) nkro_dirty_nxt = 1'b1;
              else boot_dirty_nxt = 1'b1;
            end
            OP_TICK: begin
              tick_nxt = tick_inc;
              if (tick_send) begin
                next_send_nxt  = tick_inc + {24'd0, cfg.report_gap};
                boot_dirty_nxt = 1'b0;
                nkro_dirty_nxt = 1'b0;
                n_boot_nxt     = boot_dirty_r ? CNT_W'(BOOT_WORDS) : '0;
                total_nxt      = (n_sum > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : n_sum;
                word_cnt_nxt   = '0;
                if (n_sum != '0) st_nxt = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          load          = 1'b1;
          out_type_nxt  = !sel_boot;
          out_index_nxt = sel_idx[1:0];
          out_word_nxt  = sel_word;
          out_last_nxt  = (word_cnt_r == total_r - CNT_W'(1));
          word_cnt_nxt  = word_cnt_r + CNT_W'(1);
          if (word_cnt_r == total_r - CNT_W'(1)) st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      mods_r       <= '0;
      bitmap_r     <= '0;
      boot_dirty_r <= 1'b0;
      nkro_dirty_r <= 1'b0;
      tick_r       <= '0;
      next_send_r  <= '0;
      word_cnt_r   <= '0;
      n_boot_r     <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < BOOT_KEY_SLOTS; i++) begin
        slots_r[i] <= 8'd0;
      end
    end else begin
      st_r         <= st_nxt;
      mods_r       <= mods_nxt;
      bitmap_r     <= bitmap_nxt;
      boot_dirty_r <= boot_dirty_nxt;
      nkro_dirty_r <= nkro_dirty_nxt;
      tick_r       <= tick_nxt;
      next_send_r  <= next_send_nxt;
      word_cnt_r   <= word_cnt_nxt;
      n_boot_r     <= n_boot_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
      slots_r      <= slots_nxt;
    end
    out_type_r  <= out_type_nxt;
    out_index_r <= out_index_nxt;
    out_word_r  <= out_word_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_report_type = out_type_r;
  assign out_word_index  = out_index_r;
  assign out_report_word = out_word_r;
  assign out_last        = out_last_r;

  `HKRB_ASSERT_IMP(a_emit_in_range, st_r == ST_EMIT, (word_cnt_r < total_r) && (total_r <= CNT_W'(MAX_RESULTS)))
  `HKRB_ASSERT_NEXT(a_last_ends_run, load && out_last_nxt, (st_r == ST_IDLE) && out_valid_r && out_last_r)
  `HKRB_ASSERT_NEXT(a_send_clears_dirty, send_tick, !boot_dirty_r && !nkro_dirty_r)
  `HKRB_ASSERT_IMP(a_no_pop_while_emit, st_r == ST_EMIT, !q_pop)

endmodule

`default_nettype wire

[src/hid_key_report_builder_core.sv]
`default_nettype none

// HID keyboard report builder: keeps a boot six-key report and an NKRO bitmap
// report and sends each dirty one on a time tick, once the rate gap has passed.
// The input channel carries key events, clear requests and ticks; the result
// channel carries 64-bit report words, boot report first, last set on the
// final word of a tick's run. Configuration writes take effect at once; the user
// must make them only while the block is idle, which the block does not enforce.
// Every key event, clear and tick enters a two-entry command queue after
// classification; the back end takes one command per cycle while it is idle
// and none while a sending tick emits its words.
// A sending tick then emits its words one per cycle while the receiver takes
// them, from the output register once the back end enters its emit state: up
// to five words, the ceiling of report length over eight bytes per dirty report.
// While the receiver stalls, the output word holds, the back end waits and
// in_ready falls once the queue is full.
// Reset clears all keys, modifiers, dirty flags and tick counters, sets NKRO
// mode and a report gap of two ticks.

module hid_key_report_builder_core #(
  parameter int BOOT_KEY_SLOTS    = 6,
  parameter int NKRO_REPORT_BYTES = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_kind,
  input  wire logic [7:0]                       in_key_code,
  input  wire logic [7:0]                       in_extra_mods,
  input  wire logic                             in_key_pressed,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_report_type,
  output logic [1:0]                            out_word_index,
  output logic [63:0]                           out_report_word,
  output logic                                  out_last,
  input  wire logic                             cfg_we,
  input  wire logic [hkrb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [hkrb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import hkrb_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_empty;
  cmd_t q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_NKRO_MODE:  cfg_nxt.nkro_mode  = cfg_wdata[0];
        REG_REPORT_GAP: cfg_nxt.report_gap = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nkro_mode  <= 1'b1;
      cfg_r.report_gap <= 8'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hkrb_front #(
    .NKRO_REPORT_BYTES(NKRO_REPORT_BYTES)
  ) u_front (
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_key_code   (in_key_code),
    .in_extra_mods (in_extra_mods),
    .in_key_pressed(in_key_pressed),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  hkrb_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  hkrb_back #(
    .BOOT_KEY_SLOTS   (BOOT_KEY_SLOTS),
    .NKRO_REPORT_BYTES(NKRO_REPORT_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_data         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_report_type(out_report_type),
    .out_word_index (out_word_index),
    .out_report_word(out_report_word),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire
